FILE: rtl/core/wsa_pkg.sv
package wsa_pkg;

  localparam int TEMP_W = 16;
  localparam int PRES_W = 17;
  localparam int HUM_W  = 14;
  localparam int RING_W = TEMP_W + PRES_W + HUM_W;

  // every mean fits in this many quotient bits (temperature magnitude up to 2^15)
  localparam int QUO_W  = 17;
  localparam int STEP_W = 5;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SUM   = 6'b000010,
    S_DIV_T = 6'b000100,
    S_DIV_P = 6'b001000,
    S_DIV_H = 6'b010000,
    S_OUT   = 6'b100000
  } wsa_state_t;

endpackage

FILE: rtl/core/wsa_div.sv
module wsa_div import wsa_pkg::*; #(
  parameter int CNT_W = 7,
  parameter int DIV_W = QUO_W + CNT_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [CNT_W-1:0]   divisor,
  output logic               done,
  output logic [QUO_W-1:0]   quotient
);

  logic               busy_r;
  logic               done_r;
  logic [STEP_W-1:0]  step_r;
  logic [CNT_W-1:0]   rem_r;
  logic [QUO_W-1:0]   dq_r;
  logic [CNT_W-1:0]   dvs_r;

  logic [CNT_W:0]     trial;
  logic [CNT_W:0]     diff;
  logic               ge;
  logic [CNT_W-1:0]   rem_nxt;
  logic [QUO_W-1:0]   dq_nxt;

  // restoring division, one quotient bit per cycle; the upper dividend bits
  // start as the remainder since the quotient is known to fit in QUO_W bits
  always_comb begin
    trial   = {rem_r, dq_r[QUO_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    dq_nxt  = {dq_r[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + STEP_W'(1);
      if (step_r == STEP_W'(QUO_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DIV_W-1:QUO_W];
      dq_r  <= dividend[QUO_W-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

FILE: rtl/core/windowed_sensor_average.sv
// channel | direction | handshake             | payload
// in_     | input     | in_valid / in_ready   | temperature_in, pressure_in, humidity_in
// out_    | output    | out_valid / out_ready | mean_temperature, mean_pressure,
//         |           |                       | mean_humidity, samples_held
//
// each sample runs one sum update, then three 17-step divisions on the shared
// bit-serial divider, then the output load
// in_ready is high only in the idle state; a finished beat waits in the output
// register, so the next sample can be taken and worked on while it is stalled
// synchronous active-low reset clears the window count, write slot and sums;
// the ring memory is not cleared, an entry is subtracted only once the ring is full
module windowed_sensor_average import wsa_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [TEMP_W-1:0]               in_temperature_in,
  input  logic [PRES_W-1:0]                      in_pressure_in,
  input  logic [HUM_W-1:0]                       in_humidity_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [TEMP_W-1:0]               out_mean_temperature,
  output logic [PRES_W-1:0]                      out_mean_pressure,
  output logic [HUM_W-1:0]                       out_mean_humidity,
  output logic [$clog2(DEPTH+1)-1:0]             out_samples_held
);

  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // sums are sized for DEPTH full-scale samples
  localparam int T_SUM_W  = TEMP_W + CNT_W;
  localparam int P_SUM_W  = PRES_W + CNT_W;
  localparam int H_SUM_W  = HUM_W + CNT_W;
  localparam int DIV_W    = QUO_W + CNT_W;

  wsa_state_t state_r, state_nxt;

  // window bookkeeping
  logic [ADDR_W-1:0]          slot_r;
  logic [CNT_W-1:0]           cnt_r;
  logic signed [T_SUM_W-1:0]  t_sum_r;
  logic [P_SUM_W-1:0]         p_sum_r;
  logic [H_SUM_W-1:0]         h_sum_r;

  // captured sample and the ring entry it replaces
  logic signed [TEMP_W-1:0]   t_smp_r;
  logic [PRES_W-1:0]          p_smp_r;
  logic [HUM_W-1:0]           h_smp_r;
  logic [RING_W-1:0]          ring [DEPTH];
  logic [RING_W-1:0]          rd_data_r;

  // quotients collected from the shared divider
  logic [TEMP_W-1:0]          q_t_r;
  logic [PRES_W-1:0]          q_p_r;
  logic                       div_started_r;

  // output register
  logic                       out_valid_r;
  logic signed [TEMP_W-1:0]   out_t_r;
  logic [PRES_W-1:0]          out_p_r;
  logic [HUM_W-1:0]           out_h_r;
  logic [CNT_W-1:0]           out_cnt_r;

  logic                       in_fire;
  logic                       full;
  logic signed [TEMP_W-1:0]   old_t;
  logic [PRES_W-1:0]          old_p;
  logic [HUM_W-1:0]           old_h;
  logic signed [T_SUM_W-1:0]  t_sub, t_add;
  logic [P_SUM_W-1:0]         p_sub;
  logic [H_SUM_W-1:0]         h_sub;
  logic                       t_neg;
  logic [T_SUM_W-1:0]         t_mag;
  logic                       div_start;
  logic                       div_done;
  logic [DIV_W-1:0]           div_dividend;
  logic [QUO_W-1:0]           div_quotient;
  logic                       out_load;
  logic [TEMP_W-1:0]          mean_t;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign full     = (cnt_r == CNT_W'(DEPTH));

  // ring word layout: temperature, pressure, humidity
  assign old_t = signed'(rd_data_r[RING_W-1 -: TEMP_W]);
  assign old_p = rd_data_r[PRES_W+HUM_W-1 -: PRES_W];
  assign old_h = rd_data_r[HUM_W-1:0];

  // oldest entry leaves the sums only once the ring is full
  always_comb begin
    t_sub = full ? T_SUM_W'(old_t) : '0;
    p_sub = full ? P_SUM_W'(old_p) : '0;
    h_sub = full ? H_SUM_W'(old_h) : '0;
    t_add = T_SUM_W'(t_smp_r);
  end

  // temperature divides on its magnitude so the mean truncates toward zero
  assign t_neg = t_sum_r[T_SUM_W-1];
  assign t_mag = t_neg ? T_SUM_W'(-t_sum_r) : T_SUM_W'(t_sum_r);

  always_comb begin
    unique case (state_r)
      S_DIV_T: div_dividend = DIV_W'(t_mag);
      S_DIV_P: div_dividend = DIV_W'(p_sum_r);
      S_DIV_H: div_dividend = DIV_W'(h_sum_r);
      default: div_dividend = '0;
    endcase
  end

  // one start per division state, the done pulse moves the sequencer on
  assign div_start = !div_started_r &&
                     (state_r == S_DIV_T || state_r == S_DIV_P || state_r == S_DIV_H);

  wsa_div #(
    .CNT_W (CNT_W),
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // output register frees up when empty or when its beat is taken
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign mean_t   = t_neg ? TEMP_W'(-q_t_r) : q_t_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) begin
        state_nxt = S_SUM;
      end
      S_SUM:   state_nxt = S_DIV_T;
      S_DIV_T: if (div_done && div_started_r) begin
        state_nxt = S_DIV_P;
      end
      S_DIV_P: if (div_done && div_started_r) begin
        state_nxt = S_DIV_H;
      end
      S_DIV_H: if (div_done && div_started_r) begin
        state_nxt = S_OUT;
      end
      S_OUT:   if (out_load) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      slot_r        <= '0;
      cnt_r         <= '0;
      t_sum_r       <= '0;
      p_sum_r       <= '0;
      h_sum_r       <= '0;
      div_started_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SUM) begin
        t_sum_r <= t_sum_r - t_sub + t_add;
        p_sum_r <= p_sum_r - p_sub + P_SUM_W'(p_smp_r);
        h_sum_r <= h_sum_r - h_sub + H_SUM_W'(h_smp_r);
        if (!full) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        if (slot_r == ADDR_W'(DEPTH - 1)) begin
          slot_r <= '0;
        end else begin
          slot_r <= slot_r + ADDR_W'(1);
        end
      end
      if (div_start) begin
        div_started_r <= 1'b1;
      end else if (div_done) begin
        div_started_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // sample capture, ring access and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      t_smp_r   <= in_temperature_in;
      p_smp_r   <= in_pressure_in;
      h_smp_r   <= in_humidity_in;
      rd_data_r <= ring[slot_r];
    end
    if (state_r == S_SUM) begin
      ring[slot_r] <= {t_smp_r, p_smp_r, h_smp_r};
    end
    if (state_r == S_DIV_T && div_done && div_started_r) begin
      q_t_r <= div_quotient[TEMP_W-1:0];
    end
    if (state_r == S_DIV_P && div_done && div_started_r) begin
      q_p_r <= div_quotient[PRES_W-1:0];
    end
    if (out_load) begin
      out_t_r   <= signed'(mean_t);
      out_p_r   <= q_p_r;
      out_h_r   <= div_quotient[HUM_W-1:0];
      out_cnt_r <= cnt_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_mean_temperature = out_t_r;
  assign out_mean_pressure    = out_p_r;
  assign out_mean_humidity    = out_h_r;
  assign out_samples_held     = out_cnt_r;

`ifndef NO_ASSERTIONS
  // an accepted sample goes straight to the sum update
  a_fire_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_SUM)
    else $error("sample not followed by sum update");

  // count grows by one per sample until it saturates at the window depth
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SUM |=> (cnt_r == $past(cnt_r) + CNT_W'(1)) ||
                         (cnt_r == CNT_W'(DEPTH) && $past(cnt_r) == CNT_W'(DEPTH)))
    else $error("held count stepped wrongly");

  // a result beat always averages at least one and at most DEPTH samples
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_cnt_r != '0 && out_cnt_r <= CNT_W'(DEPTH))
    else $error("result count out of range");

  // the divider start is never raised back to back
  a_div_once: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !div_start)
    else $error("divider restarted back to back");
`endif

endmodule
